// ===== rtl/color_key_to_label_mapper_defines.svh =====
// Assertion macros shared by the color key label mapper RTL.
`ifndef COLOR_KEY_TO_LABEL_MAPPER_DEFINES_SVH
`define COLOR_KEY_TO_LABEL_MAPPER_DEFINES_SVH
`ifndef SYNTHESIS
`define CKL_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define CKL_ASSERT_NORST(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define CKL_ASSERT(label, clk, rst_n, prop, msg)
`define CKL_ASSERT_NORST(label, clk, prop, msg)
`endif
`endif

// ===== rtl/ckl_pkg.sv =====
// Package: types and constants for the color key label mapper.
`timescale 1ns / 1ps
`default_nettype none
package ckl_pkg;
    localparam int TABLE_DEPTH_DEF   = 1024;
    localparam int MAX_DIMENSION_DEF = 8192;
    localparam int COLOR_W = 24;
    localparam int LABEL_W = 16;
    localparam int DIM_W   = 14;
    localparam int ADDR_W  = 26;
    localparam int INDEX_W = 10;
    localparam logic [COLOR_W-1:0] COLOR_WHITE = 24'hFFFFFF;
    localparam logic [COLOR_W-1:0] COLOR_BLACK = 24'h000000;
    localparam logic OP_LOAD  = 1'b0;
    localparam logic OP_PIXEL = 1'b1;
    localparam logic [1:0] REG_WIDTH  = 2'd0;
    localparam logic [1:0] REG_HEIGHT = 2'd1;
    localparam logic [1:0] REG_OCEAN  = 2'd2;
    localparam logic [1:0] REG_IMPASS = 2'd3;

    typedef enum logic [2:0] {
        ST_IDLE, ST_CLEAR, ST_SEARCH, ST_WAIT, ST_ADDR, ST_DONE
    } t_state;
endpackage
`default_nettype wire

// ===== rtl/ckl_ram.sv =====
// Generic single-port RAM with registered read data.
`timescale 1ns / 1ps
`default_nettype none
module ckl_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_addr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    output logic      [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        o_rdata <= r_mem[i_addr];
    end
endmodule
`default_nettype wire

// ===== rtl/color_key_to_label_mapper.sv =====
// Top level: color key to label mapper with table memory and scan control.
`timescale 1ns / 1ps
`default_nettype none
`include "color_key_to_label_mapper_defines.svh"
// Maps 24-bit pixel colors to 16-bit labels through a table held in one
// single-port RAM. After reset a clearing pass walks all TABLE_DEPTH entries,
// one a cycle, with busy high. A load transaction passes through the DONE
// state, where an in-range entry is written. A pixel that is white, black or
// repeats the previous color of its row passes through WAIT, ADDR and DONE.
// Any other pixel scans the table in SEARCH, between WAIT and ADDR, from slot 0
// until the first valid match, one slot read per cycle through the RAM port,
// or through all TABLE_DEPTH slots when the color is missing. Results appear
// for one cycle on o_valid and cannot be held off by the receiver; the next
// start is taken once busy falls.
module color_key_to_label_mapper
    import ckl_pkg::*;
#(
    parameter int TABLE_DEPTH   = ckl_pkg::TABLE_DEPTH_DEF,
    parameter int MAX_DIMENSION = ckl_pkg::MAX_DIMENSION_DEF
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_start,
    output logic                             o_busy,
    input  wire logic                        i_operation,
    input  wire logic [7:0]                  i_red,
    input  wire logic [7:0]                  i_green,
    input  wire logic [7:0]                  i_blue,
    input  wire logic [ckl_pkg::INDEX_W-1:0] i_entry_index,
    input  wire logic [ckl_pkg::LABEL_W-1:0] i_entry_label,
    input  wire logic                        i_entry_valid,
    output logic                             o_valid,
    output logic [ckl_pkg::LABEL_W-1:0]      o_label,
    output logic [ckl_pkg::ADDR_W-1:0]       o_map_address,
    output logic                             o_status,
    output logic                             o_last_pixel,
    input  wire logic                        psel,
    input  wire logic                        penable,
    input  wire logic                        pwrite,
    input  wire logic [3:0]                  paddr,
    input  wire logic [31:0]                 pwdata,
    output logic [31:0]                      prdata,
    output logic                             pready
);
    localparam int TW  = $clog2(TABLE_DEPTH);
    localparam int CW  = TW + 1;
    localparam int EW  = 1 + COLOR_W + LABEL_W;

    // configuration registers
    logic [DIM_W-1:0]   r_width, r_height;
    logic [LABEL_W-1:0] r_ocean, r_impass;
    logic               cfg_wr;
    logic [1:0]         cfg_idx;
    logic [DIM_W-1:0]   clamp_val;

    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite;
    assign cfg_idx = paddr[3:2];

    // clamp dimension writes into 1..MAX_DIMENSION
    always_comb begin
        clamp_val = pwdata[DIM_W-1:0];
        if (clamp_val == '0) begin
            clamp_val = DIM_W'(1);
        end else if (32'(clamp_val) > 32'(MAX_DIMENSION)) begin
            clamp_val = DIM_W'(MAX_DIMENSION);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width  <= DIM_W'(1);
            r_height <= DIM_W'(1);
            r_ocean  <= '0;
            r_impass <= '0;
        end else if (cfg_wr) begin
            unique case (cfg_idx)
                REG_WIDTH:  r_width  <= clamp_val;
                REG_HEIGHT: r_height <= clamp_val;
                REG_OCEAN:  r_ocean  <= pwdata[LABEL_W-1:0];
                REG_IMPASS: r_impass <= pwdata[LABEL_W-1:0];
                default: ;
            endcase
        end
    end

    // register read back
    always_comb begin
        prdata = '0;
        unique case (cfg_idx)
            REG_WIDTH:  prdata = 32'(r_width);
            REG_HEIGHT: prdata = 32'(r_height);
            REG_OCEAN:  prdata = 32'(r_ocean);
            REG_IMPASS: prdata = 32'(r_impass);
            default:    prdata = '0;
        endcase
    end

    // state
    t_state               r_state, n_state;
    logic [CW-1:0]        r_ptr, n_ptr;
    logic [COLOR_W-1:0]   r_color, n_color;
    logic [LABEL_W-1:0]   r_elabel;
    logic [INDEX_W-1:0]   r_eidx;
    logic                 r_evalid, r_op;
    logic [DIM_W-1:0]     r_col, r_row;
    logic [COLOR_W-1:0]   r_pcolor;
    logic [LABEL_W-1:0]   r_plabel;
    logic                 r_pvalid, r_pstatus;
    logic [LABEL_W-1:0]   r_lab, n_lab;
    logic                 r_stat, n_stat;
    logic [ADDR_W-1:0]    r_rowbase;
    logic                 r_last;
    logic                 accept;

    // ram port
    logic                 ram_we;
    logic [TW-1:0]        ram_addr;
    logic [EW-1:0]        ram_wdata, ram_rdata;
    logic                 hit;

    ckl_ram #(.WIDTH(EW), .DEPTH(TABLE_DEPTH)) u_table (
        .i_clk  (i_clk),
        .i_we   (ram_we),
        .i_addr (ram_addr),
        .i_wdata(ram_wdata),
        .o_rdata(ram_rdata)
    );

    assign accept = i_start && !o_busy;
    assign hit = ram_rdata[EW-1] && (ram_rdata[EW-2 -: COLOR_W] == r_color);

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_CLEAR:  if (r_ptr == CW'(TABLE_DEPTH - 1)) n_state = ST_IDLE;
            ST_IDLE: begin
                if (accept) begin
                    if (i_operation == OP_LOAD) begin
                        n_state = ST_DONE;
                    end else begin
                        n_state = ST_WAIT;
                    end
                end
            end
            ST_WAIT: begin
                if ((r_color == COLOR_WHITE) || (r_color == COLOR_BLACK)
                    || (r_col != '0 && r_pvalid && r_color == r_pcolor)) begin
                    n_state = ST_ADDR;
                end else begin
                    n_state = ST_SEARCH;
                end
            end
            ST_SEARCH: if (hit || r_ptr == CW'(TABLE_DEPTH)) n_state = ST_ADDR;
            ST_ADDR:   n_state = ST_DONE;
            ST_DONE:   n_state = ST_IDLE;
            default:   n_state = ST_IDLE;
        endcase
    end

    // datapath control and RAM drive
    always_comb begin
        n_ptr     = r_ptr;
        n_color   = r_color;
        n_lab     = r_lab;
        n_stat    = r_stat;
        ram_we    = 1'b0;
        ram_addr  = r_ptr[TW-1:0];
        ram_wdata = '0;
        unique case (r_state)
            ST_CLEAR: begin
                ram_we = 1'b1;
                n_ptr  = r_ptr + CW'(1);
            end
            ST_IDLE: begin
                n_ptr   = '0;
                ram_addr = '0;
                n_color = {i_red, i_green, i_blue};
            end
            ST_WAIT: begin
                // issue the slot 0 read; search sees it with pointer at 1
                ram_addr = '0;
                n_ptr    = CW'(1);
                n_stat   = 1'b0;
                if (r_color == COLOR_WHITE) begin
                    n_lab = r_ocean;
                end else if (r_color == COLOR_BLACK) begin
                    n_lab = r_impass;
                end else if (r_col != '0 && r_pvalid && r_color == r_pcolor) begin
                    n_lab  = r_plabel;
                    n_stat = r_pstatus;
                end
            end
            ST_SEARCH: begin
                // ram_rdata holds slot r_ptr-1
                if (hit) begin
                    n_lab  = ram_rdata[LABEL_W-1:0];
                    n_stat = 1'b0;
                end else if (r_ptr == CW'(TABLE_DEPTH)) begin
                    n_lab  = '0;
                    n_stat = 1'b1;
                end else begin
                    n_ptr    = r_ptr + CW'(1);
                    ram_addr = r_ptr[TW-1:0];
                end
            end
            ST_DONE: begin
                if (r_op == OP_LOAD && 32'(r_eidx) < 32'(TABLE_DEPTH)) begin
                    ram_we    = 1'b1;
                    ram_addr  = TW'(r_eidx);
                    ram_wdata = {r_evalid, r_color, r_elabel};
                end
            end
            default: ;
        endcase
    end

    // outputs
    always_comb begin
        o_busy = (r_state != ST_IDLE);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_CLEAR;
            r_ptr   <= '0;
        end else begin
            r_state <= n_state;
            r_ptr   <= n_ptr;
        end
    end

    always_ff @(posedge i_clk) begin
        r_color <= n_color;
        r_lab   <= n_lab;
        r_stat  <= n_stat;
        if (accept) begin
            r_op     <= i_operation;
            r_eidx   <= i_entry_index;
            r_elabel <= i_entry_label;
            r_evalid <= i_entry_valid;
        end
        // row base counted from the bottom row (height - 1 - row) and last mark, one multiply
        if (r_state == ST_WAIT) begin
            r_rowbase <= ADDR_W'(32'(r_height - DIM_W'(1) - r_row) * 32'(r_width));
            r_last    <= (r_row == r_height - DIM_W'(1)) && (r_col == r_width - DIM_W'(1));
        end
    end

    // scan position and same-color cache
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col     <= '0;
            r_row     <= '0;
            r_pcolor  <= '0;
            r_plabel  <= '0;
            r_pvalid  <= 1'b0;
            r_pstatus <= 1'b0;
        end else if (cfg_wr && (cfg_idx == REG_WIDTH || cfg_idx == REG_HEIGHT)) begin
            r_col     <= '0;
            r_row     <= '0;
            r_pcolor  <= '0;
            r_plabel  <= '0;
            r_pvalid  <= 1'b0;
            r_pstatus <= 1'b0;
        end else if (r_state == ST_DONE && r_op == OP_LOAD) begin
            r_pvalid <= 1'b0;
        end else if (r_state == ST_ADDR) begin
            r_pcolor  <= r_color;
            r_plabel  <= r_lab;
            r_pstatus <= r_stat;
            if (r_col + DIM_W'(1) >= r_width) begin
                r_col    <= '0;
                r_pvalid <= 1'b0;
                r_row    <= (r_row + DIM_W'(1) >= r_height) ? '0 : r_row + DIM_W'(1);
            end else begin
                r_col    <= r_col + DIM_W'(1);
                r_pvalid <= 1'b1;
            end
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_valid <= 1'b0;
        end else begin
            o_valid <= (r_state == ST_ADDR);
        end
        if (r_state == ST_ADDR) begin
            o_label       <= r_lab;
            o_status      <= r_stat;
            o_map_address <= r_rowbase + ADDR_W'(r_col);
            o_last_pixel  <= r_last;
        end
    end

    `CKL_ASSERT(a_err_label_zero, i_clk, i_rst_n, o_valid && o_status |-> o_label == '0, "error result with nonzero label")
    `CKL_ASSERT(a_no_start_result, i_clk, i_rst_n, accept |=> !o_valid, "result right after accept")
    `CKL_ASSERT(a_busy_on_result, i_clk, i_rst_n, (r_state == ST_ADDR) |-> o_busy, "result while idle")
    `CKL_ASSERT(a_col_range, i_clk, i_rst_n, r_col < r_width, "column past width")
endmodule
`default_nettype wire
